@@ src/sleds_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the status LED pattern sequencer.
package sleds_pkg;

    localparam logic [31:0] SLOW_PERIOD_RST = 32'd500000;
    localparam logic [31:0] FAST_PERIOD_RST = 32'd100000;
    localparam logic [31:0] HOLD_TIME_RST   = 32'd500000;
    localparam logic [31:0] DARK_TIME_RST   = 32'd300000;

    localparam int DATA_W = 32;
    localparam int CNT_W  = 8;

    typedef enum logic [1:0] {
        CFG_SLOW_PERIOD = 2'd0,
        CFG_FAST_PERIOD = 2'd1,
        CFG_HOLD_TIME   = 2'd2,
        CFG_DARK_TIME   = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        MODE_LOWBAT,
        MODE_BIND,
        MODE_FAILSAFE,
        MODE_COMMAND,
        MODE_BLINK,
        MODE_STEADY
    } mode_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_ARM,
        S_ELAPSED,
        S_DECIDE,
        S_DIV_INIT,
        S_DIV,
        S_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic eval;
        logic arm;
        logic calc_elapsed;
        logic decide;
        logic div_init;
        logic div_step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        mode_t mode_now;
        mode_t mode;
        logic  div_last;
        logic  out_free;
    } status_t;

endpackage

@@ src/status_led_pattern_sequencer_core.sv @@
`timescale 1ns / 1ps
// Top level of the status LED pattern sequencer.
// Steady on goes from evaluate to finish; a blink step adds arm, elapsed and decide; a flash
// mode adds a 32-step serial remainder by the period; command mode adds both.
// One item at a time: the next item is taken only after the last result is loaded into the
// output register. A stalled result holds the controller until it is taken.
// Reset: asynchronous active-low; configuration and sequencer state registers return to defaults, command flash armed.
module status_led_pattern_sequencer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] time_us,
    input  logic        low_battery,
    input  logic        bind_mode,
    input  logic        failsafe,
    input  logic        start_command,
    input  logic        load_blink,
    input  logic [7:0]  blink_count,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        led_on
);

    sleds_pkg::cmd_t    cmd;
    sleds_pkg::status_t status;

    sleds_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    sleds_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .time_us       (time_us),
        .low_battery   (low_battery),
        .bind_mode     (bind_mode),
        .failsafe      (failsafe),
        .start_command (start_command),
        .load_blink    (load_blink),
        .blink_count   (blink_count),
        .led_on        (led_on),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .cmd           (cmd),
        .status        (status)
    );

`ifndef SYNTH
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second item taken while one is in progress");
`endif

endmodule

@@ src/sleds_ctrl.sv @@
`timescale 1ns / 1ps
// Controller state machine sequencing one item through the datapath.
module sleds_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  sleds_pkg::status_t status,
    output sleds_pkg::cmd_t    cmd
);

    sleds_pkg::ctrl_state_t state_reg;
    sleds_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sleds_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sleds_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sleds_pkg::S_EVAL;
                end
            end
            sleds_pkg::S_EVAL:
            begin
                case (status.mode_now)
                    sleds_pkg::MODE_LOWBAT,
                    sleds_pkg::MODE_BIND,
                    sleds_pkg::MODE_FAILSAFE: state_next = sleds_pkg::S_DIV_INIT;
                    sleds_pkg::MODE_COMMAND,
                    sleds_pkg::MODE_BLINK:    state_next = sleds_pkg::S_ARM;
                    default:                  state_next = sleds_pkg::S_FINISH;
                endcase
            end
            sleds_pkg::S_ARM:     state_next = sleds_pkg::S_ELAPSED;
            sleds_pkg::S_ELAPSED: state_next = sleds_pkg::S_DECIDE;
            sleds_pkg::S_DECIDE:
            begin
                if (status.mode == sleds_pkg::MODE_COMMAND)
                begin
                    state_next = sleds_pkg::S_DIV_INIT;
                end
                else
                begin
                    state_next = sleds_pkg::S_FINISH;
                end
            end
            sleds_pkg::S_DIV_INIT: state_next = sleds_pkg::S_DIV;
            sleds_pkg::S_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = sleds_pkg::S_FINISH;
                end
            end
            sleds_pkg::S_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = sleds_pkg::S_IDLE;
                end
            end
            default: state_next = sleds_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            sleds_pkg::S_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            sleds_pkg::S_EVAL:     cmd.eval         = 1'b1;
            sleds_pkg::S_ARM:      cmd.arm          = 1'b1;
            sleds_pkg::S_ELAPSED:  cmd.calc_elapsed = 1'b1;
            sleds_pkg::S_DECIDE:   cmd.decide       = 1'b1;
            sleds_pkg::S_DIV_INIT: cmd.div_init     = 1'b1;
            sleds_pkg::S_DIV:      cmd.div_step     = 1'b1;
            sleds_pkg::S_FINISH:   cmd.finish       = status.out_free;
            default:               cmd              = '0;
        endcase
    end

endmodule

@@ src/sleds_dp.sv @@
`timescale 1ns / 1ps
// Datapath: configuration, mode state, shared timer, serial remainder unit, output register.
module sleds_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [sleds_pkg::DATA_W-1:0] cfg_data,
    input  logic [sleds_pkg::DATA_W-1:0] time_us,
    input  logic                        low_battery,
    input  logic                        bind_mode,
    input  logic                        failsafe,
    input  logic                        start_command,
    input  logic                        load_blink,
    input  logic [sleds_pkg::CNT_W-1:0]  blink_count,
    output logic                        led_on,
    output logic                        out_valid,
    input  logic                        out_stall,
    input  sleds_pkg::cmd_t             cmd,
    output sleds_pkg::status_t          status
);

    localparam int W = sleds_pkg::DATA_W;

    logic [W-1:0] slow_period_reg, fast_period_reg, hold_time_reg, dark_time_reg;

    logic                        command_active_reg, command_active_next;
    logic                        timer_armed_reg, timer_armed_next;
    logic [W-1:0]                mark_time_reg, mark_time_next;
    logic [sleds_pkg::CNT_W-1:0] blinks_left_reg, blinks_left_next;
    logic                        out_valid_reg, out_valid_next;

    logic [W-1:0]     now_reg;
    logic             lowbat_reg, bind_reg, fs_reg;
    sleds_pkg::mode_t mode_reg;
    sleds_pkg::mode_t mode_now;
    logic [W-1:0]     elapsed_reg;
    logic             led_res_reg;
    logic [W-1:0]     period_reg;
    logic [W-1:0]     thr_reg;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     dividend_reg;
    logic [4:0]       cnt_reg;
    logic             led_out_reg;

    logic [W:0]       div_tmp;
    logic [W:0]       div_diff;
    logic [W-1:0]     period_sel;
    logic [W+3:0]     prod12;
    logic [W+3:0]     prod15;
    logic [W-1:0]     thr_sel;
    logic [W-1:0]     rem_eff;
    logic             flash_led;
    logic             use_flash;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slow_period_reg <= sleds_pkg::SLOW_PERIOD_RST;
            fast_period_reg <= sleds_pkg::FAST_PERIOD_RST;
            hold_time_reg   <= sleds_pkg::HOLD_TIME_RST;
            dark_time_reg   <= sleds_pkg::DARK_TIME_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sleds_pkg::CFG_SLOW_PERIOD: slow_period_reg <= cfg_data;
                sleds_pkg::CFG_FAST_PERIOD: fast_period_reg <= cfg_data;
                sleds_pkg::CFG_HOLD_TIME:   hold_time_reg   <= cfg_data;
                sleds_pkg::CFG_DARK_TIME:   dark_time_reg   <= cfg_data;
                default:                    slow_period_reg <= slow_period_reg;
            endcase
        end
    end

    // priority of modes
    always_comb
    begin
        if (lowbat_reg)
        begin
            mode_now = sleds_pkg::MODE_LOWBAT;
        end
        else if (bind_reg)
        begin
            mode_now = sleds_pkg::MODE_BIND;
        end
        else if (fs_reg)
        begin
            mode_now = sleds_pkg::MODE_FAILSAFE;
        end
        else if (command_active_reg)
        begin
            mode_now = sleds_pkg::MODE_COMMAND;
        end
        else if (blinks_left_reg != '0)
        begin
            mode_now = sleds_pkg::MODE_BLINK;
        end
        else
        begin
            mode_now = sleds_pkg::MODE_STEADY;
        end
    end

    always_comb
    begin
        command_active_next = command_active_reg;
        timer_armed_next    = timer_armed_reg;
        mark_time_next      = mark_time_reg;
        blinks_left_next    = blinks_left_reg;
        out_valid_next      = out_valid_reg && out_stall;
        if (cmd.capture)
        begin
            if (start_command)
            begin
                command_active_next = 1'b1;
            end
            if (load_blink)
            begin
                blinks_left_next = blink_count;
            end
        end
        if (cmd.arm && !timer_armed_reg)
        begin
            timer_armed_next = 1'b1;
            mark_time_next   = now_reg;
        end
        if (cmd.decide && (elapsed_reg > hold_time_reg))
        begin
            timer_armed_next = 1'b0;
            if (mode_reg == sleds_pkg::MODE_COMMAND)
            begin
                command_active_next = 1'b0;
            end
            else
            begin
                blinks_left_next = blinks_left_reg - 8'd1;
            end
        end
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            command_active_reg <= 1'b1;
            timer_armed_reg    <= 1'b0;
            mark_time_reg      <= '0;
            blinks_left_reg    <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            command_active_reg <= command_active_next;
            timer_armed_reg    <= timer_armed_next;
            mark_time_reg      <= mark_time_next;
            blinks_left_reg    <= blinks_left_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    // flash threshold: (period * duty) >> 4
    assign period_sel = ((mode_reg == sleds_pkg::MODE_LOWBAT) ||
                         (mode_reg == sleds_pkg::MODE_FAILSAFE)) ? slow_period_reg
                                                                 : fast_period_reg;
    assign prod12 = {1'b0, period_sel, 3'b000} + {2'b00, period_sel, 2'b00};
    assign prod15 = {period_sel, 4'b0000} - {4'b0000, period_sel};

    always_comb
    begin
        case (mode_reg)
            sleds_pkg::MODE_BIND:     thr_sel = prod12[W+3:4];
            sleds_pkg::MODE_FAILSAFE: thr_sel = prod15[W+3:4];
            default:                  thr_sel = {1'b0, period_sel[W-1:1]};
        endcase
    end

    // restoring remainder, one dividend bit per cycle
    assign div_tmp  = {rem_reg, dividend_reg[W-1]};
    assign div_diff = div_tmp - {1'b0, period_reg};

    assign rem_eff   = (period_reg == '0) ? now_reg : rem_reg;
    assign flash_led = rem_eff > thr_reg;
    assign use_flash = (mode_reg != sleds_pkg::MODE_BLINK) &&
                       (mode_reg != sleds_pkg::MODE_STEADY);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            now_reg    <= time_us;
            lowbat_reg <= low_battery;
            bind_reg   <= bind_mode;
            fs_reg     <= failsafe;
        end
        if (cmd.eval)
        begin
            mode_reg    <= mode_now;
            led_res_reg <= 1'b1;
        end
        if (cmd.calc_elapsed)
        begin
            elapsed_reg <= now_reg - mark_time_reg;
        end
        if (cmd.decide)
        begin
            led_res_reg <= (elapsed_reg > hold_time_reg) || (elapsed_reg > dark_time_reg);
        end
        if (cmd.div_init)
        begin
            period_reg   <= period_sel;
            thr_reg      <= thr_sel;
            rem_reg      <= '0;
            dividend_reg <= now_reg;
            cnt_reg      <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg      <= (div_tmp >= {1'b0, period_reg}) ? div_diff[W-1:0] : div_tmp[W-1:0];
            dividend_reg <= {dividend_reg[W-2:0], 1'b0};
            cnt_reg      <= cnt_reg + 5'd1;
        end
        if (cmd.finish)
        begin
            led_out_reg <= use_flash ? flash_led : led_res_reg;
        end
    end

    assign led_on    = led_out_reg;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        status          = '0;
        status.mode_now = mode_now;
        status.mode     = mode_reg;
        status.div_last = (cnt_reg == 5'd31);
        status.out_free = !out_valid_reg || !out_stall;
    end

`ifndef SYNTH
    a_blinks_step: assert property (@(posedge clk) disable iff (!rst_n)
        ((blinks_left_reg != $past(blinks_left_reg)) && !$past(cmd.capture))
        |-> (blinks_left_reg == $past(blinks_left_reg) - 8'd1))
        else $error("blink counter moved by more than one outside a load");
    a_arm_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(timer_armed_reg) |-> $past(cmd.arm))
        else $error("timer armed without an arm command");
    a_no_load_while_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || !out_stall))
        else $error("result loaded over an unaccepted item");
`endif

endmodule

@@ test/status_led_pattern_sequencer_core_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the status LED pattern sequencer core: directed and random ticks.
module status_led_pattern_sequencer_core_tb;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 50;

    localparam logic [3:0] DUTY_LOWBAT   = 4'd8;
    localparam logic [3:0] DUTY_BIND     = 4'd12;
    localparam logic [3:0] DUTY_FAILSAFE = 4'd15;
    localparam logic [3:0] DUTY_COMMAND  = 4'd8;

    typedef struct packed {
        logic [31:0] time_us;
        logic        low_battery;
        logic        bind_mode;
        logic        failsafe;
        logic        start_command;
        logic        load_blink;
        logic [7:0]  blink_count;
    } tick_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    sleds_pkg::cfg_idx_t  cfg_index;
    logic [31:0]          cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [31:0]          time_us;
    logic                 low_battery;
    logic                 bind_mode;
    logic                 failsafe;
    logic                 start_command;
    logic                 load_blink;
    logic [7:0]           blink_count;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 led_on;

    int idle_pct  = 0;
    int stall_pct = 0;
    int err_cnt   = 0;
    int cycle_cnt = 0;

    logic led_expect_q[$];
    logic led_expected;

    // predictor copy of registers and sequencer state
    logic [31:0] slow_p;
    logic [31:0] fast_p;
    logic [31:0] hold_t;
    logic [31:0] dark_t;
    logic        cmd_on;
    logic        armed;
    logic [31:0] mark_us;
    logic [7:0]  blinks;

    status_led_pattern_sequencer_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .time_us       (time_us),
        .low_battery   (low_battery),
        .bind_mode     (bind_mode),
        .failsafe      (failsafe),
        .start_command (start_command),
        .load_blink    (load_blink),
        .blink_count   (blink_count),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .led_on        (led_on)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("[status_led_pattern_sequencer_core] ERROR");
            $finish;
        end
    end

    // result taken at the coming rising edge
    always @(negedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (led_expect_q.size() == 0)
            begin
                $display("%0t: result with nothing pending, led_on=%0b", $time, led_on);
                err_cnt++;
            end
            else
            begin
                led_expected = led_expect_q.pop_front();
                if (led_on !== led_expected)
                begin
                    $display("%0t: led_on mismatch, expected %0b, actual %0b",
                             $time, led_expected, led_on);
                    err_cnt++;
                end
            end
        end
    end

    function automatic logic flash_lit(input logic [31:0] now_us, input logic [31:0] period,
                                       input logic [3:0] duty);
        logic [31:0] rem;
        logic [63:0] thr;
        rem = (period == 32'd0) ? now_us : now_us % period;
        thr = (64'(period) * 64'(duty)) >> 4;
        return {32'd0, rem} > thr;
    endfunction

    function automatic logic next_led(input tick_t tk);
        logic [31:0] span;
        logic        lit;
        if (tk.start_command)
            cmd_on = 1'b1;
        if (tk.load_blink)
            blinks = tk.blink_count;
        if (tk.low_battery)
            lit = flash_lit(tk.time_us, slow_p, DUTY_LOWBAT);
        else if (tk.bind_mode)
            lit = flash_lit(tk.time_us, fast_p, DUTY_BIND);
        else if (tk.failsafe)
            lit = flash_lit(tk.time_us, slow_p, DUTY_FAILSAFE);
        else if (cmd_on)
        begin
            if (!armed)
            begin
                armed   = 1'b1;
                mark_us = tk.time_us;
            end
            span = tk.time_us - mark_us;
            if (span > hold_t)
            begin
                cmd_on = 1'b0;
                armed  = 1'b0;
            end
            lit = flash_lit(tk.time_us, fast_p, DUTY_COMMAND);
        end
        else if (blinks != 8'd0)
        begin
            if (!armed)
            begin
                armed   = 1'b1;
                mark_us = tk.time_us;
            end
            span = tk.time_us - mark_us;
            if (span > hold_t)
            begin
                blinks = blinks - 8'd1;
                armed  = 1'b0;
                lit    = 1'b1;
            end
            else
                lit = (span > dark_t);
        end
        else
            lit = 1'b1;
        return lit;
    endfunction

    function automatic tick_t mk_tick(input logic [31:0] t, input logic lb, input logic bm,
                                      input logic fs, input logic sc, input logic lbk,
                                      input logic [7:0] cnt);
        tick_t tk;
        tk.time_us       = t;
        tk.low_battery   = lb;
        tk.bind_mode     = bm;
        tk.failsafe      = fs;
        tk.start_command = sc;
        tk.load_blink    = lbk;
        tk.blink_count   = cnt;
        return tk;
    endfunction

    task automatic send_tick(input tick_t tk);
        bit taken;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        time_us       <= tk.time_us;
        low_battery   <= tk.low_battery;
        bind_mode     <= tk.bind_mode;
        failsafe      <= tk.failsafe;
        start_command <= tk.start_command;
        load_blink    <= tk.load_blink;
        blink_count   <= tk.blink_count;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            if (taken)
                led_expect_q.push_back(next_led(tk));
            @(posedge clk);
        end
        while (!taken);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (led_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input sleds_pkg::cfg_idx_t idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            sleds_pkg::CFG_SLOW_PERIOD: slow_p = val;
            sleds_pkg::CFG_FAST_PERIOD: fast_p = val;
            sleds_pkg::CFG_HOLD_TIME:   hold_t = val;
            sleds_pkg::CFG_DARK_TIME:   dark_t = val;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_registers(input logic [31:0] s, input logic [31:0] f,
                                 input logic [31:0] h, input logic [31:0] d);
        write_reg(sleds_pkg::CFG_SLOW_PERIOD, s);
        write_reg(sleds_pkg::CFG_FAST_PERIOD, f);
        write_reg(sleds_pkg::CFG_HOLD_TIME, h);
        write_reg(sleds_pkg::CFG_DARK_TIME, d);
    endtask

    // command flash runs from reset with the default registers
    task automatic test_command_startup();
        send_tick(mk_tick(32'd1000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0));
        send_tick(mk_tick(32'd60000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0));
        send_tick(mk_tick(32'd501001, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0));
        send_tick(mk_tick(32'd501100, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0));
    endtask

    task automatic test_flash_priority();
        drain_results();
        set_registers(32'd16, 32'd10, 32'd20, 32'd5);
        send_tick(mk_tick(32'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0));
        send_tick(mk_tick(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0));
        send_tick(mk_tick(32'd9, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'd0));
        send_tick(mk_tick(32'd7, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 8'd0));
        send_tick(mk_tick(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0));
        send_tick(mk_tick(32'd14, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'd0));
    endtask

    // zero and full-scale periods
    task automatic test_period_extremes();
        drain_results();
        set_registers(32'd0, 32'hFFFF_FFFF, 32'd20, 32'd5);
        send_tick(mk_tick(32'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0));
        send_tick(mk_tick(32'd5, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0));
        send_tick(mk_tick(32'hFFFF_FFFE, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0));
        send_tick(mk_tick(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'd0));
        drain_results();
        write_reg(sleds_pkg::CFG_SLOW_PERIOD, 32'd1);
        send_tick(mk_tick(32'd123, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'd0));
    endtask

    // blink cycles, time wrap, shared timer between command and blink
    task automatic test_blink_sequences();
        drain_results();
        set_registers(32'd16, 32'd10, 32'd20, 32'd5);
        send_tick(mk_tick(32'd100, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'd2));
        send_tick(mk_tick(32'd110, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0));
        send_tick(mk_tick(32'd121, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0));
        send_tick(mk_tick(32'd125, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0));
        send_tick(mk_tick(32'hFFFF_FFF0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0));
        send_tick(mk_tick(32'hFFFF_FFFA, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 8'd1));
        send_tick(mk_tick(32'hFFFF_FFFC, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0));
        send_tick(mk_tick(32'h0000_000F, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0));
        send_tick(mk_tick(32'h0000_0011, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0));
        send_tick(mk_tick(32'h0000_0012, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0));
        send_tick(mk_tick(32'h0000_0020, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0));
        send_tick(mk_tick(32'h0000_0021, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'd0));
        send_tick(mk_tick(32'h0000_0022, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'd0));
        send_tick(mk_tick(32'h0000_0027, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0));
    endtask

    // mostly monotonic time with sparse requests, some random noise ticks
    task automatic run_random_phase(input int n, input int idle, input int stall,
                                    input logic [31:0] s, input logic [31:0] f,
                                    input logic [31:0] h, input logic [31:0] d);
        tick_t       tk;
        logic [31:0] now_us;
        int unsigned step_cap;
        drain_results();
        set_registers(s, f, h, d);
        idle_pct  = idle;
        stall_pct = stall;
        now_us    = $urandom;
        step_cap  = (h >> 2) + 1;
        if (step_cap > 32'h0100_0000)
            step_cap = 32'h0100_0000;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 85)
            begin
                now_us = now_us + $urandom_range(step_cap);
                tk = mk_tick(now_us,
                             $urandom_range(99) < 4,
                             $urandom_range(99) < 4,
                             $urandom_range(99) < 4,
                             $urandom_range(99) < 3,
                             $urandom_range(99) < 5,
                             ($urandom_range(99) < 85) ? 8'($urandom_range(4, 1))
                                                       : 8'($urandom_range(255)));
            end
            else
            begin
                tk = mk_tick($urandom, 1'($urandom_range(1)), 1'($urandom_range(1)),
                             1'($urandom_range(1)), 1'($urandom_range(1)),
                             1'($urandom_range(1)), 8'($urandom_range(255)));
                if ($urandom_range(1))
                    now_us = tk.time_us;
            end
            send_tick(tk);
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(140, 0, 0, 32'd37, 32'd16, 32'd200, 32'd80);
        run_random_phase(140, 47, 0, 32'd1, 32'd1, 32'd0, 32'd0);
        run_random_phase(140, 0, 47, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1000, 32'd999);
        run_random_phase(140, 21, 21, 32'd0, 32'd0, 32'd64, 32'd64);
        run_random_phase(140, 0, 0, 32'd1000, 32'd300, 32'd500, 32'd0);
        run_random_phase(100, 47, 0, 32'd7, 32'd123456, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_random_phase(150, 0, 47, 32'd50000, 32'd2500, 32'd30000, 32'd12000);
        run_random_phase(150, 21, 21, 32'd3, 32'd5, 32'd20, 32'd10);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = sleds_pkg::CFG_SLOW_PERIOD;
        cfg_data      = 32'd0;
        in_valid      = 1'b0;
        time_us       = 32'd0;
        low_battery   = 1'b0;
        bind_mode     = 1'b0;
        failsafe      = 1'b0;
        start_command = 1'b0;
        load_blink    = 1'b0;
        blink_count   = 8'd0;
        slow_p        = sleds_pkg::SLOW_PERIOD_RST;
        fast_p        = sleds_pkg::FAST_PERIOD_RST;
        hold_t        = sleds_pkg::HOLD_TIME_RST;
        dark_t        = sleds_pkg::DARK_TIME_RST;
        cmd_on        = 1'b1;
        armed         = 1'b0;
        mark_us       = 32'd0;
        blinks        = 8'd0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_command_startup();
        test_flash_priority();
        test_period_extremes();
        test_blink_sequences();
        test_random_traffic();
        drain_results();

        if (err_cnt == 0)
            $display("[status_led_pattern_sequencer_core] OK");
        else
            $display("[status_led_pattern_sequencer_core] ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
src/sleds_pkg.sv
src/sleds_ctrl.sv
src/sleds_dp.sv
src/status_led_pattern_sequencer_core.sv
test/status_led_pattern_sequencer_core_tb.sv
